>>> design/dmc_pkg.sv
// shared types and constants for the disc mean color block
package dmc_pkg;

   localparam int COORD_BITS   = 12;
   localparam int CHANNEL_BITS = 8;
   localparam int MEAN_BITS    = 8;
   localparam int SUM_BITS     = 32;
   localparam int COUNT_BITS   = 25;
   localparam int DIST_BITS    = 2 * COORD_BITS + 1;
   localparam int RAD2_BITS    = 2 * COORD_BITS;
   localparam int CSR_IDX_BITS = 2;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int STEP_BITS    = $clog2(CHANNEL_BITS);
   localparam int LANES        = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISC_RADIUS = 2'd2;

   localparam logic [COORD_BITS-1:0] RADIUS_RESET = COORD_BITS'(1);

   typedef struct packed {
      logic [COORD_BITS-1:0]   pixel_x;
      logic [COORD_BITS-1:0]   pixel_y;
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
      logic                    last_pixel;
   } dmc_req_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0]  mean_red;
      logic [MEAN_BITS-1:0]  mean_green;
      logic [MEAN_BITS-1:0]  mean_blue;
      logic [COUNT_BITS-1:0] covered_total;
      logic                  empty_flag;
   } dmc_rsp_type;

   // classified pixel between front and back
   typedef struct packed {
      logic                    covered;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic                    last;
   } dmc_item_type;

   // frame totals handed to the divider
   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   red_sum;
      logic [SUM_BITS-1:0]   green_sum;
      logic [SUM_BITS-1:0]   blue_sum;
      logic [COUNT_BITS-1:0] count;
   } dmc_job_type;

endpackage

>>> design/dmc_front.sv
// front pipeline: distance to the disc centre and coverage test
module dmc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  dmc_pkg::dmc_req_type            req_data,
   input  logic [dmc_pkg::COORD_BITS-1:0]  center_x,
   input  logic [dmc_pkg::COORD_BITS-1:0]  center_y,
   input  logic [dmc_pkg::COORD_BITS-1:0]  disc_radius,
   output logic                            item_push,
   output dmc_pkg::dmc_item_type           item_data,
   input  logic                            item_full
);

   localparam int RAD2_W = dmc_pkg::RAD2_BITS;

   logic                              advance;
   logic                              v1_ff, v1_in, v2_ff, v2_in;
   logic [dmc_pkg::COORD_BITS-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [dmc_pkg::RAD2_BITS-1:0]     dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [dmc_pkg::RAD2_BITS-1:0]     rad2_ff, rad2_in;
   logic [dmc_pkg::DIST_BITS-1:0]     dist2;
   dmc_pkg::dmc_req_type              p1_ff, p1_in, p2_ff, p2_in;

   // whole pipe stalls when its last stage cannot hand over
   assign advance   = !(v2_ff && item_full);
   assign req_full  = !advance;
   assign item_push = v2_ff && !item_full;

   always_comb begin
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dx2_in  = dx2_ff;
      dy2_in  = dy2_ff;
      rad2_in = RAD2_W'(disc_radius) * RAD2_W'(disc_radius);
      if (advance) begin
         v1_in  = req_push;
         p1_in  = req_data;
         dx_in  = (req_data.pixel_x >= center_x) ? req_data.pixel_x - center_x
                                                 : center_x - req_data.pixel_x;
         dy_in  = (req_data.pixel_y >= center_y) ? req_data.pixel_y - center_y
                                                 : center_y - req_data.pixel_y;
         v2_in  = v1_ff;
         p2_in  = p1_ff;
         dx2_in = RAD2_W'(dx_ff) * RAD2_W'(dx_ff);
         dy2_in = RAD2_W'(dy_ff) * RAD2_W'(dy_ff);
      end
   end

   assign dist2 = {1'b0, dx2_ff} + {1'b0, dy2_ff};

   always_comb begin
      item_data.covered = dist2 <= {1'b0, rad2_ff};
      item_data.red     = p2_ff.red_in;
      item_data.green   = p2_ff.green_in;
      item_data.blue    = p2_ff.blue_in;
      item_data.last    = p2_ff.last_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
      rad2_ff <= rad2_in;
   end

endmodule

>>> design/dmc_fifo.sv
// short queue of classified pixels between front and back
module dmc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dmc_pkg::dmc_item_type push_data,
   output logic                  full,
   input  logic                  pop,
   output dmc_pkg::dmc_item_type pop_data,
   output logic                  empty
);

   localparam int PTR_W = dmc_pkg::FIFO_PTR_BITS;

   dmc_pkg::dmc_item_type  mem_ff [dmc_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]         cnt_ff, cnt_in;

   assign full     = cnt_ff == (PTR_W+1)'(dmc_pkg::FIFO_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> design/dmc_back.sv
// back end: per-frame channel sums and covered count
module dmc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_empty,
   input  dmc_pkg::dmc_item_type item_data,
   output logic                  item_pop,
   input  logic                  job_ready,
   output dmc_pkg::dmc_job_type  job
);

   localparam int SW = dmc_pkg::SUM_BITS;
   localparam int CW = dmc_pkg::COUNT_BITS;

   logic [SW-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [SW-1:0] red_add, green_add, blue_add;
   logic [CW-1:0] count_ff, count_in, count_add;

   // a last pixel waits here while the divider is still busy
   assign item_pop = !item_empty && (!item_data.last || job_ready);

   always_comb begin
      red_add   = red_ff;
      green_add = green_ff;
      blue_add  = blue_ff;
      count_add = count_ff;
      if (item_data.covered) begin
         red_add   = red_ff + SW'(item_data.red);
         green_add = green_ff + SW'(item_data.green);
         blue_add  = blue_ff + SW'(item_data.blue);
         count_add = count_ff + 1'b1;
      end
      job.start     = item_pop && item_data.last;
      job.red_sum   = red_add;
      job.green_sum = green_add;
      job.blue_sum  = blue_add;
      job.count     = count_add;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      count_in = count_ff;
      if (item_pop) begin
         if (item_data.last) begin
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
            count_in = '0;
         end else begin
            red_in   = red_add;
            green_in = green_add;
            blue_in  = blue_add;
            count_in = count_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         count_ff <= '0;
      end else begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> design/dmc_div.sv
// three-lane restoring divider for the channel means, with result register
module dmc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dmc_pkg::dmc_job_type job,
   output logic                 job_ready,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output dmc_pkg::dmc_rsp_type rsp_data
);

   localparam int CH   = dmc_pkg::CHANNEL_BITS;
   localparam int CW   = dmc_pkg::COUNT_BITS;
   localparam int SW   = dmc_pkg::SUM_BITS;
   localparam int NL   = dmc_pkg::LANES;
   localparam int STW  = dmc_pkg::STEP_BITS;
   localparam int MW   = dmc_pkg::MEAN_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_STEP,
      S_HOLD
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        rem_ff  [NL];
   logic [CH-1:0]        quo_ff  [NL];
   logic                 sat_ff  [NL];
   logic [CW-1:0]        rem_in  [NL];
   logic [CH-1:0]        quo_in  [NL];
   logic                 sat_in  [NL];
   logic [SW-1:0]        sums    [NL];
   logic [MW-1:0]        mean    [NL];
   logic [CW:0]          trial   [NL];
   logic                 fits    [NL];
   logic [STW-1:0]       step_ff;
   logic                 out_valid_ff;
   dmc_pkg::dmc_rsp_type out_ff;
   logic                 can_load;

   assign job_ready = state_ff == S_IDLE;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign can_load  = !out_valid_ff || rsp_pop;

   assign sums[0] = job.red_sum;
   assign sums[1] = job.green_sum;
   assign sums[2] = job.blue_sum;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         sat_in[l] = sat_ff[l];
         trial[l]  = {rem_ff[l], quo_ff[l][CH-1]};
         fits[l]   = trial[l] >= {1'b0, count_ff};
         unique case (state_ff)
            S_IDLE: begin
               // high part starts the remainder, low bits come down one a step
               rem_in[l] = CW'(sums[l][SW-1:CH]);
               quo_in[l] = sums[l][CH-1:0];
            end
            S_CHECK: begin
               sat_in[l] = rem_ff[l] >= count_ff;
            end
            S_STEP: begin
               rem_in[l] = fits[l] ? CW'(trial[l] - {1'b0, count_ff}) : CW'(trial[l]);
               quo_in[l] = {quo_ff[l][CH-2:0], fits[l]};
            end
            S_HOLD: begin
               rem_in[l] = rem_ff[l];
            end
            default: begin
               rem_in[l] = rem_ff[l];
            end
         endcase
         if (count_ff == '0) begin
            mean[l] = '0;
         end else if (sat_ff[l]) begin
            mean[l] = MW'({CH{1'b1}});
         end else begin
            mean[l] = MW'(quo_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (rsp_pop && !(state_ff == S_HOLD && can_load)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job.start) begin
                  count_ff <= job.count;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               step_ff  <= '0;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STW'(CH - 1)) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (can_load) begin
                  out_valid_ff         <= 1'b1;
                  out_ff.mean_red      <= mean[0];
                  out_ff.mean_green    <= mean[1];
                  out_ff.mean_blue     <= mean[2];
                  out_ff.covered_total <= count_ff;
                  out_ff.empty_flag    <= count_ff == '0;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      for (int l = 0; l < NL; l++) begin
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
         sat_ff[l] <= sat_in[l];
      end
   end

endmodule

>>> design/disc_mean_color.sv
// top level: configuration registers and the front, queue, back and divider
// Pixels are taken one per cycle while req_full is low and are classified by a
// two-stage front pipeline (absolute offsets, then squares against the squared
// radius) before a four-beat queue feeds the accumulators, which also take one
// pixel per cycle while the queue is not empty. The beat marked last_pixel closes
// the frame: its totals go to a three-lane restoring divider, whose means are
// loaded into the result register once the previous result has been popped.
// A following last pixel waits in the queue while the divider is busy;
// back-pressure then reaches req_full. Centre writes take effect for pixels
// pushed on any later cycle; a radius write also reaches pixels already in the
// front pipeline. Configuration writes are meant for when no pixel is in flight.
module disc_mean_color (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  dmc_pkg::dmc_req_type                req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output dmc_pkg::dmc_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [dmc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dmc_pkg::COORD_BITS-1:0]      csr_wdata
);

   logic [dmc_pkg::COORD_BITS-1:0] center_x_ff, center_y_ff, radius_ff;
   logic                           item_push, item_full, item_pop, item_empty;
   logic                           job_ready;
   dmc_pkg::dmc_item_type          item_in, item_out;
   dmc_pkg::dmc_job_type           job;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= dmc_pkg::RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dmc_pkg::CSR_CENTER_X:    center_x_ff <= csr_wdata;
            dmc_pkg::CSR_CENTER_Y:    center_y_ff <= csr_wdata;
            dmc_pkg::CSR_DISC_RADIUS: radius_ff   <= csr_wdata;
            default: begin
               radius_ff <= radius_ff;
            end
         endcase
      end
   end

   dmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .disc_radius (radius_ff),
      .item_push   (item_push),
      .item_data   (item_in),
      .item_full   (item_full)
   );

   dmc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item_in),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (item_out),
      .empty     (item_empty)
   );

   dmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_data  (item_out),
      .item_pop   (item_pop),
      .job_ready  (job_ready),
      .job        (job)
   );

   dmc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_ready (job_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
